// ----- sv/cndl_pkg.sv -----
// shared types and constants for the candlestick pattern classifier
// no dependencies; used by cndl_classify and candlestick_pattern_classifier
package cndl_pkg;

    localparam int PRICE_BITS_DEF = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;
    localparam int RES_W          = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HAMMER_RATIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOJI_RATIO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOJI_DIV     = 2'd2;

    localparam logic [CFG_DATA_W-1:0] HAMMER_RATIO_RST = 8'd2;
    localparam logic [CFG_DATA_W-1:0] DOJI_RATIO_RST   = 8'd10;
    localparam logic [CFG_DATA_W-1:0] DOJI_DIV_RST     = 8'd4;

    localparam logic [1:0] STAR_NONE    = 2'd0;
    localparam logic [1:0] STAR_MORNING = 2'd1;
    localparam logic [1:0] STAR_EVENING = 2'd2;

    localparam logic [1:0] DOJI_NONE       = 2'd0;
    localparam logic [1:0] DOJI_LONG_LEG   = 2'd1;
    localparam logic [1:0] DOJI_DRAGONFLY  = 2'd2;
    localparam logic [1:0] DOJI_GRAVESTONE = 2'd3;

    localparam int PAT_STRICT_ENGULF  = 0;
    localparam int PAT_RELAXED_ENGULF = 1;
    localparam int PAT_STRICT_HARAMI  = 2;
    localparam int PAT_RELAXED_HARAMI = 3;
    localparam int PAT_PIERCE_CLOUD   = 4;

    typedef logic [1:0] t_hist_cnt;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] hammer_ratio;
        logic [CFG_DATA_W-1:0] doji_ratio;
        logic [CFG_DATA_W-1:0] doji_div;
    } t_cfg;

    // packed lsb last: bull_patterns sits in the lowest bits
    typedef struct packed {
        logic [1:0] doji_kind;
        logic       hammer_seen;
        logic [1:0] star_kind;
        logic [4:0] bear_patterns;
        logic [4:0] bull_patterns;
    } t_result;

endpackage

// ----- sv/cndl_classify.sv -----
// combinational pattern tests for one candle against the held history
// depends on cndl_pkg
module cndl_classify #(
    parameter int PRICE_BITS = cndl_pkg::PRICE_BITS_DEF
) (
    input  logic [PRICE_BITS-1:0] i_open,
    input  logic [PRICE_BITS-1:0] i_high,
    input  logic [PRICE_BITS-1:0] i_low,
    input  logic [PRICE_BITS-1:0] i_close,
    input  logic [PRICE_BITS-1:0] i_prior_open,
    input  logic [PRICE_BITS-1:0] i_prior_high,
    input  logic [PRICE_BITS-1:0] i_prior_low,
    input  logic [PRICE_BITS-1:0] i_prior_close,
    input  logic [PRICE_BITS-1:0] i_older_open,
    input  logic [PRICE_BITS-1:0] i_older_close,
    input  cndl_pkg::t_hist_cnt   i_hist_cnt,
    input  cndl_pkg::t_cfg        i_cfg,
    output cndl_pkg::t_result     o_res
);

    localparam int PW = PRICE_BITS + 1;
    localparam int MW = PW + cndl_pkg::CFG_DATA_W + 1;

    logic signed [PW-1:0] s_open, s_high, s_low, s_close;
    logic signed [PW-1:0] top, bot, body, top_l, bot_l, h_top, rng;
    logic signed [cndl_pkg::CFG_DATA_W:0] hr, dr, dd, ddm1;
    logic signed [MW-1:0] hammer_prod, doji_prod, drag_lhs, drag_rhs, grave_lhs;
    logic [PRICE_BITS:0] two_close, prior_sum;
    logic bull_pair, bear_pair, have1, have2;
    logic [PRICE_BITS-1:0] o, h, l, c, po, ph, pl, pc, oo, oc;

    assign o  = i_open;
    assign h  = i_high;
    assign l  = i_low;
    assign c  = i_close;
    assign po = i_prior_open;
    assign ph = i_prior_high;
    assign pl = i_prior_low;
    assign pc = i_prior_close;
    assign oo = i_older_open;
    assign oc = i_older_close;

    assign s_open  = $signed({1'b0, o});
    assign s_high  = $signed({1'b0, h});
    assign s_low   = $signed({1'b0, l});
    assign s_close = $signed({1'b0, c});

    assign top   = (o > c) ? s_open : s_close;
    assign bot   = (o > c) ? s_close : s_open;
    assign body  = top - bot;
    assign top_l = top - s_low;
    assign bot_l = bot - s_low;
    assign h_top = s_high - top;
    assign rng   = s_high - s_low;

    assign hr   = $signed({1'b0, i_cfg.hammer_ratio});
    assign dr   = $signed({1'b0, i_cfg.doji_ratio});
    assign dd   = (i_cfg.doji_div == '0) ? $signed((cndl_pkg::CFG_DATA_W+1)'(1))
                                         : $signed({1'b0, i_cfg.doji_div});
    assign ddm1 = dd - $signed((cndl_pkg::CFG_DATA_W+1)'(1));

    assign hammer_prod = MW'(hr) * MW'(body);
    assign doji_prod   = MW'(dr) * MW'(body);
    assign drag_lhs    = MW'(bot_l) * MW'(dd);
    assign drag_rhs    = MW'(rng) * MW'(ddm1);
    assign grave_lhs   = MW'(top_l) * MW'(dd);

    assign two_close = {c, 1'b0};
    assign prior_sum = (PRICE_BITS+1)'(po) + (PRICE_BITS+1)'(pc);

    assign have1     = (i_hist_cnt != '0);
    assign have2     = i_hist_cnt[1];
    assign bull_pair = have1 && (po > pc) && (o < c);
    assign bear_pair = have1 && (po < pc) && (o > c);

    always_comb begin
        o_res = '0;
        if (bull_pair) begin
            o_res.bull_patterns[cndl_pkg::PAT_STRICT_ENGULF]  = (o < pl) && (c > ph);
            o_res.bull_patterns[cndl_pkg::PAT_RELAXED_ENGULF] = (o < pc) && (c > po);
            o_res.bull_patterns[cndl_pkg::PAT_STRICT_HARAMI]  = (h < po) && (l > pc);
            o_res.bull_patterns[cndl_pkg::PAT_RELAXED_HARAMI] = (c < po) && (o > pc);
            o_res.bull_patterns[cndl_pkg::PAT_PIERCE_CLOUD]   =
                (o < pl) && (two_close > prior_sum);
        end
        if (bear_pair) begin
            o_res.bear_patterns[cndl_pkg::PAT_STRICT_ENGULF]  = (o > ph) && (c < pl);
            o_res.bear_patterns[cndl_pkg::PAT_RELAXED_ENGULF] = (o > pc) && (c < po);
            o_res.bear_patterns[cndl_pkg::PAT_STRICT_HARAMI]  = (h < pc) && (l > po);
            o_res.bear_patterns[cndl_pkg::PAT_RELAXED_HARAMI] = (o < pc) && (c > po);
            o_res.bear_patterns[cndl_pkg::PAT_PIERCE_CLOUD]   =
                (o > ph) && (two_close < prior_sum);
        end
        if (have2) begin
            if ((oo > oc) && (o < c) && (oc > po) && (oc > pc) && (o > po) && (o > pc)) begin
                o_res.star_kind = cndl_pkg::STAR_MORNING;
            end else if ((oo < oc) && (o > c) && (oc < po) && (oc < pc)
                         && (o < po) && (o < pc)) begin
                o_res.star_kind = cndl_pkg::STAR_EVENING;
            end
        end
        o_res.hammer_seen = (MW'(top_l) > hammer_prod) && (body > h_top);
        if (MW'(rng) > doji_prod) begin
            if (drag_lhs > drag_rhs) begin
                o_res.doji_kind = cndl_pkg::DOJI_DRAGONFLY;
            end else if (grave_lhs < MW'(rng)) begin
                o_res.doji_kind = cndl_pkg::DOJI_GRAVESTONE;
            end else begin
                o_res.doji_kind = cndl_pkg::DOJI_LONG_LEG;
            end
        end
    end

endmodule

// ----- sv/candlestick_pattern_classifier.sv -----
// top level: candle stream in, pattern result stream out, config write port
// throughput one candle per cycle unless i_m_tready stalls the result register
// input register, then classify logic, then result register
// synchronous active-low reset clears history and pipeline valids and loads config defaults
// depends on cndl_pkg and cndl_classify
module candlestick_pattern_classifier #(
    parameter int PRICE_BITS = cndl_pkg::PRICE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // open_price, high_price, low_price, close_price, zero pad
    input  logic [((4*PRICE_BITS+7)/8)*8-1:0]     i_s_tdata,
    // last_in_series
    input  logic                                  i_s_tlast,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // bull_patterns, bear_patterns, star_kind, hammer_seen, doji_kind, zero pad
    output logic [cndl_pkg::RES_W-1:0]            o_m_tdata,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cndl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [cndl_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int PB = PRICE_BITS;

    logic [PB-1:0] r_po, r_ph, r_pl, r_pc, r_oo, r_oc;
    cndl_pkg::t_hist_cnt r_cnt;

    logic [PB-1:0] r_in_o, r_in_h, r_in_l, r_in_c;
    logic [PB-1:0] r_in_po, r_in_ph, r_in_pl, r_in_pc, r_in_oo, r_in_oc;
    cndl_pkg::t_hist_cnt r_in_cnt;
    logic r_in_vld;

    cndl_pkg::t_result r_res, n_res;
    logic r_out_vld;
    cndl_pkg::t_cfg r_cfg;

    logic in_acc, adv;
    logic [PB-1:0] d_o, d_h, d_l, d_c;

    assign d_o = i_s_tdata[PB-1:0];
    assign d_h = i_s_tdata[2*PB-1:PB];
    assign d_l = i_s_tdata[3*PB-1:2*PB];
    assign d_c = i_s_tdata[4*PB-1:3*PB];

    assign adv        = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_in_vld || adv;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = cndl_pkg::RES_W'(r_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hammer_ratio <= cndl_pkg::HAMMER_RATIO_RST;
            r_cfg.doji_ratio   <= cndl_pkg::DOJI_RATIO_RST;
            r_cfg.doji_div     <= cndl_pkg::DOJI_DIV_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cndl_pkg::CFG_HAMMER_RATIO: r_cfg.hammer_ratio <= i_cfg_data;
                cndl_pkg::CFG_DOJI_RATIO:   r_cfg.doji_ratio   <= i_cfg_data;
                cndl_pkg::CFG_DOJI_DIV:     r_cfg.doji_div     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // history follows the accepted stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_po  <= '0;
            r_ph  <= '0;
            r_pl  <= '0;
            r_pc  <= '0;
            r_oo  <= '0;
            r_oc  <= '0;
            r_cnt <= '0;
        end else if (in_acc) begin
            if (i_s_tlast) begin
                r_po  <= '0;
                r_ph  <= '0;
                r_pl  <= '0;
                r_pc  <= '0;
                r_oo  <= '0;
                r_oc  <= '0;
                r_cnt <= '0;
            end else begin
                r_oo <= r_po;
                r_oc <= r_pc;
                r_po <= d_o;
                r_ph <= d_h;
                r_pl <= d_l;
                r_pc <= d_c;
                if (!r_cnt[1]) begin
                    r_cnt <= r_cnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_o   <= d_o;
            r_in_h   <= d_h;
            r_in_l   <= d_l;
            r_in_c   <= d_c;
            r_in_po  <= r_po;
            r_in_ph  <= r_ph;
            r_in_pl  <= r_pl;
            r_in_pc  <= r_pc;
            r_in_oo  <= r_oo;
            r_in_oc  <= r_oc;
            r_in_cnt <= r_cnt;
        end
    end

    cndl_classify #(
        .PRICE_BITS (PRICE_BITS)
    ) u_classify (
        .i_open        (r_in_o),
        .i_high        (r_in_h),
        .i_low         (r_in_l),
        .i_close       (r_in_c),
        .i_prior_open  (r_in_po),
        .i_prior_high  (r_in_ph),
        .i_prior_low   (r_in_pl),
        .i_prior_close (r_in_pc),
        .i_older_open  (r_in_oo),
        .i_older_close (r_in_oc),
        .i_hist_cnt    (r_in_cnt),
        .i_cfg         (r_cfg),
        .o_res         (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_vld) begin
            r_res <= n_res;
        end
    end

endmodule

// ----- bench/tb_candlestick_pattern_classifier.sv -----
// self-checking bench for candlestick_pattern_classifier: candle words in, pattern words out
// predicts each pattern word from its own copy of the history and registers
// depends on cndl_pkg and the classifier rtl
module tb_candlestick_pattern_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRICE_BITS = cndl_pkg::PRICE_BITS_DEF;
    localparam int DATA_W = ((4 * PRICE_BITS + 7) / 8) * 8;
    localparam longint PRICE_MAX = (longint'(1) << PRICE_BITS) - 1;
    localparam logic [cndl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic [PRICE_BITS-1:0] open_px;
        logic [PRICE_BITS-1:0] high_px;
        logic [PRICE_BITS-1:0] low_px;
        logic [PRICE_BITS-1:0] close_px;
        logic                  series_end;
        bit                    wait_drain;
    } t_candle_word;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_s_tvalid = 1'b0;
    logic                                  o_s_tready;
    logic [DATA_W-1:0]                     i_s_tdata = '0;
    logic                                  i_s_tlast = 1'b0;
    logic                                  o_m_tvalid;
    logic                                  i_m_tready = 1'b0;
    logic [cndl_pkg::RES_W-1:0]            o_m_tdata;
    logic                                  i_cfg_valid = 1'b0;
    logic                                  o_cfg_ready;
    logic [cndl_pkg::CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [cndl_pkg::CFG_DATA_W-1:0]       i_cfg_data = '0;

    candlestick_pattern_classifier #(
        .PRICE_BITS(PRICE_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register copies
    logic [cndl_pkg::CFG_DATA_W-1:0] hammer_ratio_q = cndl_pkg::HAMMER_RATIO_RST;
    logic [cndl_pkg::CFG_DATA_W-1:0] doji_ratio_q = cndl_pkg::DOJI_RATIO_RST;
    logic [cndl_pkg::CFG_DATA_W-1:0] doji_div_q = cndl_pkg::DOJI_DIV_RST;

    // candle history copies
    longint    prev_open = 0, prev_high = 0, prev_low = 0, prev_close = 0;
    longint    old_open = 0, old_close = 0;
    cndl_pkg::t_hist_cnt held_count = '0;

    t_candle_word      candle_queue[$];
    cndl_pkg::t_result pattern_due[$];
    t_candle_word      on_bus;
    cndl_pkg::t_result predicted, got_word, want_word;
    bit                drain_next = 1'b0;
    longint            walk_base = 64'd1000000;

    int  candles_queued = 0, candles_sent = 0, words_checked = 0;
    int  fail_count = 0, cycle_count = 0, settings_used = 1, series_ends = 0;
    int  bull_hits = 0, bear_hits = 0, star_hits = 0, hammer_hits = 0, doji_hits = 0;
    logic calm;

    assign calm = (candles_sent >= 520) && (candles_sent < 900);

    function automatic cndl_pkg::t_result classify_candle(input t_candle_word cw);
        cndl_pkg::t_result r;
        longint o, h, l, c, top, bot, body, rng, dv, hr, dr;
        r = '0;
        o = longint'(cw.open_px);
        h = longint'(cw.high_px);
        l = longint'(cw.low_px);
        c = longint'(cw.close_px);
        top = (o > c) ? o : c;
        bot = (o > c) ? c : o;
        body = top - bot;
        rng = h - l;
        hr = longint'(hammer_ratio_q);
        dr = longint'(doji_ratio_q);
        dv = (doji_div_q == '0) ? 1 : longint'(doji_div_q);

        if (held_count >= 1) begin
            if (prev_open > prev_close && o < c) begin
                r.bull_patterns[cndl_pkg::PAT_STRICT_ENGULF] =
                    (o < prev_low) && (c > prev_high);
                r.bull_patterns[cndl_pkg::PAT_RELAXED_ENGULF] =
                    (o < prev_close) && (c > prev_open);
                r.bull_patterns[cndl_pkg::PAT_STRICT_HARAMI] =
                    (h < prev_open) && (l > prev_close);
                r.bull_patterns[cndl_pkg::PAT_RELAXED_HARAMI] =
                    (c < prev_open) && (o > prev_close);
                r.bull_patterns[cndl_pkg::PAT_PIERCE_CLOUD] =
                    (o < prev_low) && (2 * c > prev_open + prev_close);
            end
            if (prev_open < prev_close && o > c) begin
                r.bear_patterns[cndl_pkg::PAT_STRICT_ENGULF] =
                    (o > prev_high) && (c < prev_low);
                r.bear_patterns[cndl_pkg::PAT_RELAXED_ENGULF] =
                    (o > prev_close) && (c < prev_open);
                r.bear_patterns[cndl_pkg::PAT_STRICT_HARAMI] =
                    (h < prev_close) && (l > prev_open);
                r.bear_patterns[cndl_pkg::PAT_RELAXED_HARAMI] =
                    (o < prev_close) && (c > prev_open);
                r.bear_patterns[cndl_pkg::PAT_PIERCE_CLOUD] =
                    (o > prev_high) && (2 * c < prev_open + prev_close);
            end
        end

        if (held_count >= 2) begin
            if (old_open > old_close && o < c && old_close > prev_open
                && old_close > prev_close && o > prev_open && o > prev_close) begin
                r.star_kind = cndl_pkg::STAR_MORNING;
            end else if (old_open < old_close && o > c && old_close < prev_open
                && old_close < prev_close && o < prev_open && o < prev_close) begin
                r.star_kind = cndl_pkg::STAR_EVENING;
            end
        end

        r.hammer_seen = ((top - l) > hr * body) && (body > (h - top));

        if (rng > dr * body) begin
            if ((bot - l) * dv > rng * (dv - 1)) begin
                r.doji_kind = cndl_pkg::DOJI_DRAGONFLY;
            end else if ((top - l) * dv < rng) begin
                r.doji_kind = cndl_pkg::DOJI_GRAVESTONE;
            end else begin
                r.doji_kind = cndl_pkg::DOJI_LONG_LEG;
            end
        end

        if (cw.series_end) begin
            prev_open = 0;
            prev_high = 0;
            prev_low = 0;
            prev_close = 0;
            old_open = 0;
            old_close = 0;
            held_count = '0;
        end else begin
            old_open = prev_open;
            old_close = prev_close;
            prev_open = o;
            prev_high = h;
            prev_low = l;
            prev_close = c;
            if (held_count < 2) held_count = held_count + 1'b1;
        end
        return r;
    endfunction

    // candle driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predicted = classify_candle(on_bus);
                pattern_due.push_back(predicted);
                candles_sent++;
                if (on_bus.series_end) series_ends++;
                if (predicted.bull_patterns != '0) bull_hits++;
                if (predicted.bear_patterns != '0) bear_hits++;
                if (predicted.star_kind != cndl_pkg::STAR_NONE) star_hits++;
                if (predicted.hammer_seen) hammer_hits++;
                if (predicted.doji_kind != cndl_pkg::DOJI_NONE) doji_hits++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (candle_queue.size() != 0
                    && !(candle_queue[0].wait_drain && pattern_due.size() != 0)
                    && (calm || $urandom_range(99) >= 6)) begin
                    on_bus = candle_queue.pop_front();
                    i_s_tdata <= {on_bus.close_px, on_bus.low_px, on_bus.high_px,
                                  on_bus.open_px};
                    i_s_tlast <= on_bus.series_end;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string name, input logic [4:0] want_v,
                                input logic [4:0] got_v);
        if (want_v !== got_v) begin
            fail_count++;
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want_v, got_v);
        end
    endtask

    // pattern word monitor
    always @(posedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(99) >= 6);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_word = o_m_tdata[$bits(cndl_pkg::t_result)-1:0];
            if (pattern_due.size() == 0) begin
                fail_count++;
                $display("%0t unexpected word: expected none actual %0h", $time, got_word);
            end else begin
                want_word = pattern_due.pop_front();
                words_checked++;
                report_field("bull_patterns", want_word.bull_patterns, got_word.bull_patterns);
                report_field("bear_patterns", want_word.bear_patterns, got_word.bear_patterns);
                report_field("star_kind", want_word.star_kind, got_word.star_kind);
                report_field("hammer_seen", want_word.hammer_seen, got_word.hammer_seen);
                report_field("doji_kind", want_word.doji_kind, got_word.doji_kind);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     pattern_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [PRICE_BITS-1:0] clip(input longint v);
        if (v < 0) return '0;
        if (v > PRICE_MAX) return '1;
        return v[PRICE_BITS-1:0];
    endfunction

    function automatic longint urand_to(input longint n);
        return longint'($urandom_range(32'(n)));
    endfunction

    function automatic longint jitter(input longint span);
        return longint'($urandom_range(32'(2 * span))) - span;
    endfunction

    task automatic push_candle(input logic [PRICE_BITS-1:0] o, input logic [PRICE_BITS-1:0] h,
                               input logic [PRICE_BITS-1:0] l, input logic [PRICE_BITS-1:0] c,
                               input logic last_flag);
        t_candle_word cw;
        cw.open_px = o;
        cw.high_px = h;
        cw.low_px = l;
        cw.close_px = c;
        cw.series_end = last_flag;
        cw.wait_drain = drain_next;
        drain_next = 1'b0;
        candle_queue.push_back(cw);
        candles_queued++;
    endtask

    // adds shadows around a body, optionally with low above high or above the body
    task automatic push_shaped(input longint o, input longint c, input longint s,
                               input bit flip, input logic last_flag);
        longint hi, lo, t, b;
        t = (o > c) ? o : c;
        b = (o > c) ? c : o;
        hi = t + (($urandom_range(3) == 0) ? 0 : urand_to(s));
        lo = b - (($urandom_range(3) == 0) ? 0 : urand_to(s * $urandom_range(1, 8)));
        if (flip) begin
            if ($urandom_range(1)) begin
                lo = hi;
                hi = b - urand_to(s);
            end else begin
                lo = t + 1 + urand_to(s);
            end
        end
        push_candle(clip(o), clip(hi), clip(lo), clip(c), last_flag);
    endtask

    task automatic step_walk(input longint s);
        if ($urandom_range(63) == 0) begin
            case ($urandom_range(3))
                0: walk_base = 0;
                1: walk_base = PRICE_MAX;
                default: walk_base = longint'($urandom);
            endcase
        end else begin
            walk_base = walk_base + jitter(s);
        end
        if (walk_base < 0) walk_base = 0;
        if (walk_base > PRICE_MAX) walk_base = PRICE_MAX;
    endtask

    task automatic push_random_candle();
        longint s, o, c;
        int unsigned pick;
        pick = $urandom_range(99);
        s = longint'(1) << $urandom_range(0, 10);
        step_walk(s);
        if (pick < 8) begin
            push_candle(PRICE_BITS'($urandom), PRICE_BITS'($urandom), PRICE_BITS'($urandom),
                        PRICE_BITS'($urandom), 1'($urandom_range(1)));
        end else begin
            o = walk_base + jitter(s);
            c = ($urandom_range(5) == 0) ? o : o + jitter(s);
            push_shaped(o, c, s, pick < 16, $urandom_range(99) < 3);
        end
    endtask

    // star triples and two-candle reversals with random sizes, s = +1 leans bearish
    task automatic push_sequence();
        longint g, b, s, o2, c2, o, c;
        g = longint'(1) << $urandom_range(0, 12);
        step_walk(g);
        b = walk_base;
        s = $urandom_range(1) ? 1 : -1;
        if ($urandom_range(1)) begin
            push_shaped(b - s * (2 * g + urand_to(g)), b, g, 1'b0, 1'b0);
            o2 = b + s * urand_to(g);
            c2 = b + s * urand_to(g);
            push_shaped(o2, c2, g, 1'b0, 1'b0);
            if (s > 0) o = ((o2 < c2) ? o2 : c2) - urand_to(g);
            else o = ((o2 > c2) ? o2 : c2) + urand_to(g);
            c = o - s * urand_to(2 * g);
            push_shaped(o, c, g, 1'b0, 1'b0);
        end else begin
            push_shaped(b - s * (1 + urand_to(2 * g)), b + s * (1 + urand_to(2 * g)), g,
                        1'b0, 1'b0);
            o = b + s * (urand_to(3 * g) - g);
            c = o - s * (1 + urand_to(4 * g));
            push_shaped(o, c, g, 1'b0, 1'b0);
        end
    endtask

    // every queued word accepted and every pattern word checked
    task automatic wait_idle();
        @(posedge i_clk);
        while (candles_sent != candles_queued || pattern_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [cndl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cndl_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            cndl_pkg::CFG_HAMMER_RATIO: hammer_ratio_q = val;
            cndl_pkg::CFG_DOJI_RATIO:   doji_ratio_q = val;
            cndl_pkg::CFG_DOJI_DIV:     doji_div_q = val;
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [cndl_pkg::CFG_DATA_W-1:0] hammer_v,
                             input logic [cndl_pkg::CFG_DATA_W-1:0] doji_v,
                             input logic [cndl_pkg::CFG_DATA_W-1:0] div_v, input int count);
        int target;
        wait_idle();
        write_reg(cndl_pkg::CFG_HAMMER_RATIO, hammer_v);
        write_reg(cndl_pkg::CFG_DOJI_RATIO, doji_v);
        write_reg(cndl_pkg::CFG_DOJI_DIV, div_v);
        write_reg(CFG_SPARE, cndl_pkg::CFG_DATA_W'($urandom_range(255)));
        settings_used++;
        target = candles_queued + count;
        while (candles_queued < target) begin
            if (candles_queued == target - count / 2) drain_next = 1'b1;
            if ($urandom_range(99) < 25) push_sequence();
            else push_random_candle();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes, then a series end
        push_candle('0, '0, '0, '0, 1'b0);
        push_candle('1, '1, '1, '1, 1'b0);
        push_candle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        push_candle(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        // bearish candle on empty history, then bullish engulfing with piercing
        push_candle(200, 210, 90, 100, 1'b0);
        push_candle(80, 230, 70, 220, 1'b0);
        // bearish harami
        push_candle(200, 210, 100, 120, 1'b0);
        // morning star
        push_candle(500, 510, 290, 300, 1'b0);
        push_candle(250, 265, 240, 260, 1'b0);
        push_candle(270, 410, 265, 400, 1'b0);
        // evening star
        push_candle(100, 310, 90, 300, 1'b0);
        push_candle(350, 360, 335, 340, 1'b0);
        push_candle(330, 335, 140, 150, 1'b0);
        // bullish harami
        push_candle(300, 310, 90, 100, 1'b0);
        push_candle(150, 250, 140, 200, 1'b0);
        // bearish engulfing with dark cloud
        push_candle(100, 210, 90, 200, 1'b0);
        push_candle(220, 230, 70, 80, 1'b0);
        // hammer, then dragonfly, gravestone and long-legged doji
        push_candle(100, 112, 50, 110, 1'b0);
        push_candle(100, 101, 0, 100, 1'b0);
        push_candle(1, 100, 0, 1, 1'b0);
        push_candle(50, 100, 0, 50, 1'b0);
        // low above high, then low above the body
        push_candle(100, 50, 200, 120, 1'b0);
        push_candle(100, 300, 150, 120, 1'b1);

        run_phase(8'd0, 8'd0, 8'd0, 270);
        run_phase(8'd255, 8'd255, 8'd255, 270);
        run_phase(8'd1, 8'd1, 8'd1, 270);
        run_phase(cndl_pkg::CFG_DATA_W'($urandom_range(255)),
                  cndl_pkg::CFG_DATA_W'($urandom_range(255)),
                  cndl_pkg::CFG_DATA_W'($urandom_range(255)), 270);
        run_phase(cndl_pkg::HAMMER_RATIO_RST, cndl_pkg::DOJI_RATIO_RST,
                  cndl_pkg::DOJI_DIV_RST, 270);
        run_phase(8'd3, 8'd20, 8'd2, 270);
        wait_idle();

        $display("covered %0d candles (%0d series ends) under %0d register settings",
                 candles_sent, series_ends, settings_used);
        $display("%0d words checked; hits: bull %0d bear %0d star %0d hammer %0d doji %0d",
                 words_checked, bull_hits, bear_hits, star_hits, hammer_hits, doji_hits);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
